// File: rtl/fcpu_pkg.sv
// Shared types, codes and fixed-point constants for the fly camera pose block.
// Depends on nothing; the CORDIC, square root, divider and top-level files import it.
package fcpu_pkg;

  // Item kinds carried in the mode field
  typedef enum logic [1:0] {
    MODE_LOOK = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_LOAD = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  // Move directions
  typedef enum logic [1:0] {
    DIR_FWD   = 2'd0,
    DIR_BACK  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SPEED = 3'd0,
    CFG_SENS  = 3'd1,
    CFG_UPX   = 3'd2,
    CFG_UPY   = 3'd3,
    CFG_UPZ   = 3'd4
  } cfg_idx_t;

  // Vector being rebuilt
  typedef enum logic [1:0] {
    TGT_FRONT = 2'd0,
    TGT_RIGHT = 2'd1,
    TGT_UP    = 2'd2
  } tgt_t;

  // Angles in Q.16 degrees
  localparam logic signed [29:0] DEG89  = 30'sd5832704;
  localparam logic signed [29:0] DEG90  = 30'sd5898240;
  localparam logic signed [29:0] DEG180 = 30'sd11796480;
  localparam logic signed [29:0] DEG360 = 30'sd23592960;

  localparam logic [15:0]        SPEED_RST = 16'd2560;
  localparam logic [15:0]        SENS_RST  = 16'd9830;
  localparam logic signed [15:0] ONE_Q14   = 16'sd16384;

  localparam int                 CORDIC_N = 17;
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

  // Arctangent of 2^-i in Q.16 degrees
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/fcpu_cordic.sv
// Iterative rotation-mode CORDIC: cosine and sine of a Q9.16 degree angle.
// One micro-rotation per cycle; uses fcpu_pkg for the arctangent table.
module fcpu_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [25:0] angle,
  output logic               done,
  output logic signed [33:0] cos_val,
  output logic signed [33:0] sin_val
);
  import fcpu_pkg::*;

  logic signed [33:0] x, y, xs, ys;
  logic signed [27:0] z, at, a_ext;
  logic               neg, busy;
  logic [4:0]         step;

  assign a_ext = {{2{angle[25]}}, angle};
  assign xs    = x >>> step;
  assign ys    = y >>> step;
  assign at    = $signed({6'b0, atan_q16(step)});

  assign cos_val = neg ? -x : x;
  assign sin_val = neg ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 5'd0;
        x    <= CORDIC_K;
        y    <= 34'sd0;
        // fold into [-90, 90] and negate the result
        if (a_ext > DEG90) begin
          z   <= 28'(a_ext - DEG180);
          neg <= 1'b1;
        end else if (a_ext < -DEG90) begin
          z   <= 28'(a_ext + DEG180);
          neg <= 1'b1;
        end else begin
          z   <= a_ext;
          neg <= 1'b0;
        end
      end else if (busy) begin
        if (step == 5'(CORDIC_N)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (z >= 0) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
          step <= step + 5'd1;
        end
      end
    end
  end

endmodule

// File: rtl/fcpu_isqrt.sv
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// Uses fcpu_pkg only for the house import.
module fcpu_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import fcpu_pkg::*;

  logic [63:0] n, r, b;
  logic [64:0] trial;
  logic        busy;

  assign trial = {1'b0, r} + {1'b0, b};
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        n    <= radicand;
        r    <= 64'd0;
        b    <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if ({1'b0, n} >= trial) begin
          n <= n - trial[63:0];
          r <= (r >> 1) + b;
        end else begin
          r <= r >> 1;
        end
        b <= b >> 2;
        if (b == 64'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/fcpu_div.sv
// Restoring divider for normalization: 15-bit quotient, one bit per cycle.
// The quotient never exceeds 16384 because each component is at most the length.
module fcpu_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [46:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [14:0] quo
);
  import fcpu_pkg::*;

  logic [46:0] rem, shifted;
  logic [31:0] d;
  logic [3:0]  idx;
  logic        busy;

  assign shifted = {15'b0, d} << idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= num;
        d    <= den;
        idx  <= 4'd14;
        quo  <= 15'd0;
      end else if (busy) begin
        if (rem >= shifted) begin
          rem      <= rem - shifted;
          quo[idx] <= 1'b1;
        end
        if (idx == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx - 4'd1;
        end
      end
    end
  end

endmodule

// File: rtl/fly_camera_pose_update.sv
// Top level of the first-person camera pose block: sequencer, shared multiplier,
// pose state and stream ports. Depends on fcpu_pkg, fcpu_cordic, fcpu_isqrt, fcpu_div.
//
// The block holds a camera pose (Q16.16 position, Q9.16 degree yaw and pitch,
// Q1.14 front/right/up unit vectors) and returns the full pose once per input
// transfer. Items are handled one at a time: s_tready is high only while the
// sequencer is idle, and a finished pose waits in the m_tdata register so the
// next item can already be taken. A look or load item runs two 17-step CORDIC
// passes, then for each of the three vectors a square root and three restoring
// divisions, which dominate; a large yaw or pitch sum is wrapped one turn at a
// time. A move item goes through the shared 33x33 multiplier, and an unused mode
// goes straight to the output. Configuration writes land at once and do not
// rebuild the vectors; the next look or load item picks up the new world up
// vector.
module fly_camera_pose_update (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // mode[1:0], mouse_dx[17:2], mouse_dy[33:18], clamp_pitch[34], move_dir[36:35],
  // time_step[52:37], load_x[84:53], load_y[116:85], load_z[148:117], zero fill
  input  logic [151:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_pos_x[31:0], out_pos_y[63:32], out_pos_z[95:64], out_front_x/y/z[143:96],
  // out_right_x/y/z[191:144], out_up_x/y/z[239:192]
  output logic [239:0] m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import fcpu_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_LK0   = 18'h00002,
    ST_LK1   = 18'h00004,
    ST_LK2   = 18'h00008,
    ST_WRAP  = 18'h00010,
    ST_TRIGY = 18'h00020,
    ST_TRIGP = 18'h00040,
    ST_FM0   = 18'h00080,
    ST_FM1   = 18'h00100,
    ST_FM2   = 18'h00200,
    ST_NSQ   = 18'h00400,
    ST_NSQRT = 18'h00800,
    ST_NDIV  = 18'h01000,
    ST_CROSS = 18'h02000,
    ST_MV0   = 18'h04000,
    ST_MV1   = 18'h08000,
    ST_MV2   = 18'h10000,
    ST_OUT   = 18'h20000
  } state_t;

  state_t state;
  tgt_t   tgt, tgt_after;
  state_t state_after;

  // pose and configuration
  logic signed [31:0] pos [3];
  logic signed [25:0] yaw, pitch;
  logic signed [15:0] front [3];
  logic signed [15:0] right [3];
  logic signed [15:0] upv [3];
  logic signed [15:0] wup [3];
  logic [15:0]        move_speed, look_sens;

  // captured item fields
  logic signed [15:0] dx, dy;
  logic               clamp;
  dir_t               dir;
  logic [15:0]        tstep;

  // working registers
  logic signed [29:0] wa, wb;
  logic signed [32:0] cy, sy, cp, sp;
  logic signed [32:0] vin [3];
  logic [31:0]        mag [3];
  logic [63:0]        acc;
  logic [31:0]        len;
  logic signed [31:0] tmp;
  logic [31:0]        vel;
  logic [2:0]         cnt;
  logic               go;

  // shared multiplier, product registered
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // arithmetic units
  logic               cord_done, sq_done, div_done;
  logic signed [33:0] cos_v, sin_v;
  logic [31:0]        root;
  logic [14:0]        quo;
  logic [46:0]        div_num;

  fcpu_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (go && (state == ST_TRIGY || state == ST_TRIGP)),
    .angle   ((state == ST_TRIGY) ? yaw : pitch),
    .done    (cord_done),
    .cos_val (cos_v),
    .sin_val (sin_v)
  );

  fcpu_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (go && state == ST_NSQRT),
    .radicand (acc),
    .done     (sq_done),
    .root     (root)
  );

  fcpu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (go && state == ST_NDIV),
    .num   (div_num),
    .den   (len),
    .done  (div_done),
    .quo   (quo)
  );

  // rounded products
  logic signed [33:0] rnd4_w;
  logic signed [65:0] r30, r22;
  assign rnd4_w = ($signed(prod[33:0]) + 34'sd8) >>> 4;
  assign r30    = (prod + (66'sd1 <<< 29)) >>> 30;
  assign r22    = (prod + (66'sd1 <<< 21)) >>> 22;

  // magnitudes of the vector being normalized
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = vin[k][32] ? 32'(-vin[k]) : vin[k][31:0];
    end
  end

  assign div_num = {1'b0, mag[cnt[1:0]], 14'b0} + {16'b0, len[31:1]};

  // normalized component with sign and saturation
  logic [14:0]        qsat;
  logic signed [15:0] qcomp;
  assign qsat  = (quo > 15'd16384) ? 15'd16384 : quo;
  assign qcomp = vin[cnt[1:0]][32] ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});

  // cross product operands: right = front x world up, up = right x front
  logic signed [15:0] ca [3];
  logic signed [15:0] cb [3];
  logic [1:0]         ai, bi;
  logic [2:0]         ck;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ca[k] = (tgt == TGT_RIGHT) ? front[k] : right[k];
      cb[k] = (tgt == TGT_RIGHT) ? wup[k]   : front[k];
    end
  end

  always_comb begin
    unique case (cnt)
      3'd0:    begin ai = 2'd1; bi = 2'd2; end
      3'd1:    begin ai = 2'd2; bi = 2'd1; end
      3'd2:    begin ai = 2'd2; bi = 2'd0; end
      3'd3:    begin ai = 2'd0; bi = 2'd2; end
      3'd4:    begin ai = 2'd0; bi = 2'd1; end
      3'd5:    begin ai = 2'd1; bi = 2'd0; end
      default: begin ai = 2'd0; bi = 2'd0; end
    endcase
  end
  assign ck = cnt - 3'd1;

  // move step
  logic               use_front, move_sub;
  logic [1:0]         cm1;
  logic signed [33:0] pbase, pnew;
  logic signed [31:0] psat;
  assign use_front = (dir == DIR_FWD) || (dir == DIR_BACK);
  assign move_sub  = (dir == DIR_BACK) || (dir == DIR_LEFT);
  assign cm1       = 2'(cnt - 3'd1);

  always_comb begin
    pbase = 34'sd0;
    if (cnt != 3'd0) begin
      pbase = {{2{pos[cm1][31]}}, pos[cm1]};
    end
    pnew = move_sub ? (pbase - r22[33:0]) : (pbase + r22[33:0]);
    if (pnew > 34'sd2147483647) begin
      psat = 32'sh7FFF_FFFF;
    end else if (pnew < -34'sd2147483648) begin
      psat = 32'sh8000_0000;
    end else begin
      psat = pnew[31:0];
    end
  end

  // angle wrap and clamp
  logic               yaw_ok, pit_ok;
  logic signed [29:0] wb_clamp;
  assign yaw_ok   = (wa < DEG180) && (wa >= -DEG180);
  assign pit_ok   = clamp || ((wb < DEG180) && (wb >= -DEG180));
  assign wb_clamp = (wb > DEG89) ? DEG89 : ((wb < -DEG89) ? -DEG89 : wb);

  // what follows a finished normalization
  always_comb begin
    unique case (tgt)
      TGT_FRONT: begin state_after = ST_CROSS; tgt_after = TGT_RIGHT; end
      TGT_RIGHT: begin state_after = ST_CROSS; tgt_after = TGT_UP;    end
      default:   begin state_after = ST_OUT;   tgt_after = TGT_UP;    end
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    unique case (state)
      ST_LK0: begin
        mul_a = {{17{dx[15]}}, dx};
        mul_b = {17'b0, look_sens};
      end
      ST_LK1: begin
        mul_a = {{17{dy[15]}}, dy};
        mul_b = {17'b0, look_sens};
      end
      ST_FM0: begin
        mul_a = cy;
        mul_b = cp;
      end
      ST_FM1: begin
        mul_a = sy;
        mul_b = cp;
      end
      ST_NSQ: begin
        if (cnt < 3'd3) begin
          mul_a = {1'b0, mag[cnt[1:0]]};
          mul_b = {1'b0, mag[cnt[1:0]]};
        end
      end
      ST_MV0: begin
        mul_a = {17'b0, move_speed};
        mul_b = {17'b0, tstep};
      end
      ST_MV2: begin
        if (cnt < 3'd3) begin
          mul_a = use_front ? {{17{front[cnt[1:0]][15]}}, front[cnt[1:0]]}
                            : {{17{right[cnt[1:0]][15]}}, right[cnt[1:0]]};
          mul_b = {1'b0, vel};
        end
      end
      ST_CROSS: begin
        if (cnt < 3'd6) begin
          mul_a = {{17{ca[ai][15]}}, ca[ai]};
          mul_b = {{17{cb[bi][15]}}, cb[bi]};
        end
      end
      default: begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
      end
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tgt        <= TGT_FRONT;
      cnt        <= 3'd0;
      go         <= 1'b0;
      m_tvalid   <= 1'b0;
      move_speed <= SPEED_RST;
      look_sens  <= SENS_RST;
      wup[0]     <= 16'sd0;
      wup[1]     <= ONE_Q14;
      wup[2]     <= 16'sd0;
      for (int k = 0; k < 3; k++) begin
        pos[k] <= 32'sd0;
      end
      yaw      <= 26'(-DEG90);
      pitch    <= 26'sd0;
      front[0] <= 16'sd0;
      front[1] <= 16'sd0;
      front[2] <= -ONE_Q14;
      right[0] <= ONE_Q14;
      right[1] <= 16'sd0;
      right[2] <= 16'sd0;
      upv[0]   <= 16'sd0;
      upv[1]   <= ONE_Q14;
      upv[2]   <= 16'sd0;
    end else begin
      go <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SPEED: move_speed <= cfg_data;
          CFG_SENS:  look_sens  <= cfg_data;
          CFG_UPX:   wup[0]     <= cfg_data;
          CFG_UPY:   wup[1]     <= cfg_data;
          CFG_UPZ:   wup[2]     <= cfg_data;
          default:   ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            dx    <= s_tdata[17:2];
            dy    <= s_tdata[33:18];
            clamp <= s_tdata[34];
            dir   <= dir_t'(s_tdata[36:35]);
            tstep <= s_tdata[52:37];
            unique case (mode_t'(s_tdata[1:0]))
              MODE_LOOK: state <= ST_LK0;
              MODE_MOVE: state <= ST_MV0;
              MODE_LOAD: begin
                pos[0] <= s_tdata[84:53];
                pos[1] <= s_tdata[116:85];
                pos[2] <= s_tdata[148:117];
                yaw    <= 26'(-DEG90);
                pitch  <= 26'sd0;
                go     <= 1'b1;
                state  <= ST_TRIGY;
              end
              default:   state <= ST_OUT;
            endcase
          end
        end
        ST_LK0: state <= ST_LK1;
        ST_LK1: begin
          wa    <= {{4{yaw[25]}}, yaw} + rnd4_w[29:0];
          state <= ST_LK2;
        end
        ST_LK2: begin
          wb    <= {{4{pitch[25]}}, pitch} + rnd4_w[29:0];
          state <= ST_WRAP;
        end
        ST_WRAP: begin
          // fold one turn per cycle until yaw, and pitch unless clamped, sit in [-180, 180)
          if (yaw_ok && pit_ok) begin
            yaw   <= wa[25:0];
            pitch <= clamp ? wb_clamp[25:0] : wb[25:0];
            go    <= 1'b1;
            state <= ST_TRIGY;
          end else begin
            if (wa >= DEG180) begin
              wa <= wa - DEG360;
            end else if (wa < -DEG180) begin
              wa <= wa + DEG360;
            end
            if (!clamp) begin
              if (wb >= DEG180) begin
                wb <= wb - DEG360;
              end else if (wb < -DEG180) begin
                wb <= wb + DEG360;
              end
            end
          end
        end
        ST_TRIGY: begin
          if (cord_done) begin
            cy    <= cos_v[32:0];
            sy    <= sin_v[32:0];
            go    <= 1'b1;
            state <= ST_TRIGP;
          end
        end
        ST_TRIGP: begin
          if (cord_done) begin
            cp    <= cos_v[32:0];
            sp    <= sin_v[32:0];
            state <= ST_FM0;
          end
        end
        ST_FM0: state <= ST_FM1;
        ST_FM1: begin
          vin[0] <= r30[32:0];
          state  <= ST_FM2;
        end
        ST_FM2: begin
          vin[2] <= r30[32:0];
          vin[1] <= sp;
          tgt    <= TGT_FRONT;
          cnt    <= 3'd0;
          state  <= ST_NSQ;
        end
        ST_NSQ: begin
          // accumulate the squares one product behind the launch
          if (cnt == 3'd1) begin
            acc <= prod[63:0];
          end else if (cnt != 3'd0) begin
            acc <= acc + prod[63:0];
          end
          if (cnt == 3'd3) begin
            go    <= 1'b1;
            state <= ST_NSQRT;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_NSQRT: begin
          if (sq_done) begin
            len <= root;
            cnt <= 3'd0;
            if (root == 32'd0) begin
              // zero length: keep the previous vector
              state <= state_after;
              tgt   <= tgt_after;
            end else begin
              go    <= 1'b1;
              state <= ST_NDIV;
            end
          end
        end
        ST_NDIV: begin
          if (div_done) begin
            unique case (tgt)
              TGT_FRONT: front[cnt[1:0]] <= qcomp;
              TGT_RIGHT: right[cnt[1:0]] <= qcomp;
              default:   upv[cnt[1:0]]   <= qcomp;
            endcase
            if (cnt == 3'd2) begin
              cnt   <= 3'd0;
              state <= state_after;
              tgt   <= tgt_after;
            end else begin
              cnt <= cnt + 3'd1;
              go  <= 1'b1;
            end
          end
        end
        ST_CROSS: begin
          if (cnt != 3'd0) begin
            if (!ck[0]) begin
              tmp <= prod[31:0];
            end else begin
              vin[ck[2:1]] <= {tmp[31], tmp} - {prod[31], prod[31:0]};
            end
          end
          if (cnt == 3'd6) begin
            cnt   <= 3'd0;
            state <= ST_NSQ;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_MV0: state <= ST_MV1;
        ST_MV1: begin
          vel   <= prod[31:0];
          cnt   <= 3'd0;
          state <= ST_MV2;
        end
        ST_MV2: begin
          if (cnt != 3'd0) begin
            pos[cm1] <= psat;
          end
          if (cnt == 3'd3) begin
            cnt   <= 3'd0;
            state <= ST_OUT;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_OUT: begin
          // hold until the previous pose has been taken
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {upv[2], upv[1], upv[0], right[2], right[1], right[0],
                         front[2], front[1], front[0], pos[2], pos[1], pos[0]};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/fcpu_checker.sv
// Port-level checks for the fly camera pose block, bound to the top level.
// Depends on fly_camera_pose_update's port names.
module fcpu_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [239:0] m_tdata
);
  logic signed [15:0] fx, ux;
  assign fx = m_tdata[111:96];
  assign ux = m_tdata[207:192];

  // one item at a time: busy right after a transfer in
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while busy");

  // a new pose only appears after a busy period
  a_out_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("pose appeared without work");

  // a stalled pose holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("pending pose changed");

  // front x and up x components stay within one in Q1.14
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (fx <= 16'sd16384 && fx >= -16'sd16384 &&
                  ux <= 16'sd16384 && ux >= -16'sd16384))
    else $error("vector component out of range");

endmodule

bind fly_camera_pose_update fcpu_checker u_fcpu_checker (.*);

// File: bench/fly_camera_pose_update_tb.sv
// Self-checking bench for fly_camera_pose_update: random bursty stream traffic,
// a clocked pose predictor and a field-by-field comparison of returned poses.
// Depends on fcpu_pkg and the RTL top level; reads no files.
`timescale 1ns / 1ps

module fly_camera_pose_update_tb;
  import fcpu_pkg::*;

  localparam longint D90  = 64'sd5898240;
  localparam longint D89  = 64'sd5832704;
  localparam longint D180 = 64'sd11796480;
  localparam longint D360 = 64'sd23592960;
  localparam int     STALL_LIMIT = 20000;
  localparam int     DRAIN_CYCLES = 400;

  typedef struct {
    mode_t              mode;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic               clamp;
    dir_t               dir;
    logic [15:0]        tstep;
    logic signed [31:0] ld [3];
  } cam_item_t;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [15:0] vec [9];   // front xyz, right xyz, up xyz
  } pose_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [151:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [239:0] m_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_data;

  fly_camera_pose_update i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Pose tracked by the predictor
  logic signed [31:0] cam_pos [3];
  int                 yaw_deg;
  int                 pitch_deg;
  logic signed [15:0] front [3];
  logic signed [15:0] right [3];
  logic signed [15:0] up [3];
  logic [15:0]        speed_q88;
  logic [15:0]        sens_q016;
  logic signed [15:0] world_up [3];

  cam_item_t pending_items [$];
  pose_t     expected_poses [$];
  cam_item_t held_item;
  int        errors;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic int wrap_deg(longint a);
    longint r;
    r = (a + D180) % D360;
    if (r < 0) r += D360;
    return int'(r - D180);
  endfunction

  // Rotation-mode CORDIC in Q2.30; fold into [-90,90] and negate afterwards
  task automatic sin_cos(input longint a, output longint c, output longint s);
    longint atan_tab [17] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                              58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                              229, 115, 57};
    longint x, y, z, nx, ny;
    bit     flip;
    x = 64'sd652032874;
    y = 0;
    flip = 1'b0;
    if (a > D90) begin
      a -= D180;
      flip = 1'b1;
    end else if (a < -D90) begin
      a += D180;
      flip = 1'b1;
    end
    z = a;
    for (int i = 0; i < 17; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += atan_tab[i];
      end
      x = nx;
      y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Zero length keeps the previous vector
  task automatic to_unit(input longint v [3], ref logic signed [15:0] u [3]);
    longint unsigned mag [3];
    longint unsigned sum, len, q;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      sum += mag[i] * mag[i];
    end
    if (sum == 0) return;
    len = floor_sqrt(sum);
    if (len == 0) return;
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 16384 + len / 2) / len;
      if (q > 16384) q = 16384;
      u[i] = (v[i] < 0) ? -16'(q) : 16'(q);
    end
  endtask

  function automatic void cross3(input logic signed [15:0] a [3],
                                 input logic signed [15:0] b [3], output longint c [3]);
    c[0] = longint'(a[1]) * b[2] - longint'(a[2]) * b[1];
    c[1] = longint'(a[2]) * b[0] - longint'(a[0]) * b[2];
    c[2] = longint'(a[0]) * b[1] - longint'(a[1]) * b[0];
  endfunction

  task automatic rebuild_basis();
    longint cy, sy, cp, sp;
    longint f [3];
    longint c [3];
    sin_cos(longint'(yaw_deg), cy, sy);
    sin_cos(longint'(pitch_deg), cp, sp);
    f[0] = round_shift(cy * cp, 30);
    f[1] = sp;
    f[2] = round_shift(sy * cp, 30);
    to_unit(f, front);
    cross3(front, world_up, c);
    to_unit(c, right);
    cross3(right, front, c);
    to_unit(c, up);
  endtask

  task automatic apply_item(input cam_item_t it);
    longint yaw, pitch, vel, step, p;
    pose_t  res;
    case (it.mode)
      MODE_LOOK: begin
        yaw   = yaw_deg + round_shift(longint'(it.dx) * sens_q016, 4);
        pitch = pitch_deg + round_shift(longint'(it.dy) * sens_q016, 4);
        yaw_deg = wrap_deg(yaw);
        if (it.clamp) begin
          if (pitch > D89) pitch = D89;
          if (pitch < -D89) pitch = -D89;
          pitch_deg = int'(pitch);
        end else begin
          pitch_deg = wrap_deg(pitch);
        end
        rebuild_basis();
      end
      MODE_MOVE: begin
        vel = longint'(speed_q88) * longint'(it.tstep);
        for (int i = 0; i < 3; i++) begin
          step = round_shift(longint'((it.dir inside {DIR_FWD, DIR_BACK}) ? front[i]
                                                                           : right[i]) * vel, 22);
          p = (it.dir inside {DIR_BACK, DIR_LEFT}) ? cam_pos[i] - step : cam_pos[i] + step;
          if (p > 64'sd2147483647) p = 64'sd2147483647;
          if (p < -64'sd2147483648) p = -64'sd2147483648;
          cam_pos[i] = p[31:0];
        end
      end
      MODE_LOAD: begin
        for (int i = 0; i < 3; i++) cam_pos[i] = it.ld[i];
        yaw_deg = -int'(D90);
        pitch_deg = 0;
        rebuild_basis();
      end
      default: ;  // unused mode: pose unchanged
    endcase
    for (int i = 0; i < 3; i++) begin
      res.pos[i]   = cam_pos[i];
      res.vec[i]   = front[i];
      res.vec[3+i] = right[i];
      res.vec[6+i] = up[i];
    end
    expected_poses.push_back(res);
  endtask

  // ---------------------------------------------------------------- driver

  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left <= $urandom_range(1, 12);
      gap_left   <= 0;
    end else begin
      // record the transfer that completes on this edge
      if (s_tvalid && s_tready) apply_item(held_item);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          held_item = pending_items.pop_front();
          s_tdata <= {3'b0, held_item.ld[2], held_item.ld[1], held_item.ld[0],
                      held_item.tstep, held_item.dir, held_item.clamp,
                      held_item.dy, held_item.dx, held_item.mode};
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            // no gap at all in about a third of the bursts
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  int    cyc;
  string vec_names [9] = '{"out_front_x", "out_front_y", "out_front_z",
                           "out_right_x", "out_right_y", "out_right_z",
                           "out_up_x", "out_up_y", "out_up_z"};
  string pos_names [3] = '{"out_pos_x", "out_pos_y", "out_pos_z"};

  always @(posedge clk) begin
    pose_t exp_pose;
    logic signed [31:0] got_pos;
    logic signed [15:0] got_vec;
    if (rst) begin
      m_tready <= 1'b0;
      cyc <= 0;
    end else begin
      cyc <= cyc + 1;
      // stall pattern cycles through free-running, 50 percent and heavy stalls
      case ((cyc >> 9) % 3)
        0:       m_tready <= 1'b1;
        1:       m_tready <= $urandom_range(0, 1);
        default: m_tready <= ($urandom_range(0, 15) == 0);
      endcase
      if (m_tvalid && m_tready) begin
        if (expected_poses.size() == 0) begin
          $error("pose transfer with nothing expected");
          errors++;
        end else begin
          exp_pose = expected_poses.pop_front();
          for (int i = 0; i < 3; i++) begin
            got_pos = m_tdata[32*i +: 32];
            if (got_pos !== exp_pose.pos[i]) begin
              $error("%s expected %0d got %0d", pos_names[i], exp_pose.pos[i], got_pos);
              errors++;
            end
          end
          for (int i = 0; i < 9; i++) begin
            got_vec = m_tdata[96 + 16*i +: 16];
            if (got_vec !== exp_pose.vec[i]) begin
              $error("%s expected %0d got %0d", vec_names[i], exp_pose.vec[i], got_vec);
              errors++;
            end
          end
        end
      end
    end
  end

  // Watchdog: abort once nothing has moved on either side for too long
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic cam_item_t make_item(mode_t m);
    cam_item_t it;
    it.mode  = m;
    it.dx    = $urandom();
    it.dy    = $urandom();
    it.clamp = $urandom_range(0, 1);
    it.dir   = dir_t'($urandom_range(0, 3));
    it.tstep = $urandom();
    for (int i = 0; i < 3; i++) it.ld[i] = $urandom();
    return it;
  endfunction

  function automatic cam_item_t random_item();
    cam_item_t it;
    int        pick;
    pick = $urandom_range(0, 99);
    it = make_item(pick < 45 ? MODE_LOOK : pick < 80 ? MODE_MOVE :
                   pick < 90 ? MODE_LOAD : MODE_NONE);
    // mostly small mouse motion so pitch stays near the clamp region
    if ($urandom_range(0, 3) != 0) begin
      it.dx = $urandom_range(0, 800) - 400;
      it.dy = $urandom_range(0, 800) - 400;
    end
    // keep loaded positions moderate most of the time, edges now and then
    if ($urandom_range(0, 3) != 0)
      for (int i = 0; i < 3; i++) it.ld[i] = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    return it;
  endfunction

  task automatic write_regs(input logic [15:0] spd, input logic [15:0] sens,
                            input logic signed [15:0] ux, input logic signed [15:0] uy,
                            input logic signed [15:0] uz);
    logic [15:0] vals [5];
    vals = '{spd, sens, ux, uy, uz};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    speed_q88   = spd;
    sens_q016   = sens;
    world_up[0] = ux;
    world_up[1] = uy;
    world_up[2] = uz;
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !s_tvalid && expected_poses.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push(input cam_item_t it);
    pending_items.push_back(it);
  endtask

  initial begin
    cam_item_t it;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_SPEED;
    cfg_data  = '0;
    errors    = 0;
    held_item = make_item(MODE_NONE);
    for (int i = 0; i < 3; i++) begin
      cam_pos[i] = 0;
      front[i] = 0;
      right[i] = 0;
      up[i] = 0;
      world_up[i] = 0;
    end
    yaw_deg     = -int'(D90);
    pitch_deg   = 0;
    front[2]    = -16384;
    right[0]    = 16384;
    up[1]       = 16384;
    world_up[1] = 16384;
    speed_q88   = SPEED_RST;
    sens_q016   = SENS_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: reset pose, unused mode, mouse extremes with and without clamp, moves in every direction
    it = make_item(MODE_NONE);
    push(it);
    it = make_item(MODE_LOOK); it.dx = 0; it.dy = 0; it.clamp = 0; push(it);
    it = make_item(MODE_LOOK); it.dx = 16'sh7fff; it.dy = 16'sh7fff; it.clamp = 1; push(it);
    it = make_item(MODE_LOOK); it.dx = 16'sh8000; it.dy = 16'sh8000; it.clamp = 1; push(it);
    it = make_item(MODE_LOOK); it.dx = 16'sh7fff; it.dy = 16'sh7fff; it.clamp = 0; push(it);
    it = make_item(MODE_LOOK); it.dx = 16'sh8000; it.dy = 16'sh8000; it.clamp = 0; push(it);
    for (int d = 0; d < 4; d++) begin
      it = make_item(MODE_MOVE); it.dir = dir_t'(d); it.tstep = 16'hffff; push(it);
      it = make_item(MODE_MOVE); it.dir = dir_t'(d); it.tstep = 16'h0000; push(it);
    end
    // load at the position extremes, then push past them to saturate
    it = make_item(MODE_LOAD);
    it.ld = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff};
    push(it);
    for (int d = 0; d < 4; d++) begin
      it = make_item(MODE_MOVE); it.dir = dir_t'(d); it.tstep = 16'hffff; push(it);
    end
    it = make_item(MODE_LOAD);
    it.ld = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0};
    push(it);
    it = make_item(MODE_NONE); push(it);
    drain();

    // phases of register settings, each opened by a load, then random items
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_regs(16'hffff, 16'hffff, 16'sd0, 16'sd0, 16'sd16384);  // up along front
        1: write_regs(16'h0000, 16'h0000, -16'sd16384, -16'sd16384, -16'sd16384);
        2: write_regs(16'd0, 16'd0, 16'sd0, 16'sd0, 16'sd0);            // zero world up
        3: write_regs($urandom(), $urandom(), $urandom_range(0, 32768) - 16384,
                      $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
        default: write_regs(SPEED_RST, SENS_RST, 16'sd0, ONE_Q14, 16'sd0);
      endcase
      it = make_item(MODE_LOAD);
      push(it);
      for (int n = 0; n < 80; n++) push(random_item());
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/fcpu_pkg.sv
rtl/fcpu_cordic.sv
rtl/fcpu_isqrt.sv
rtl/fcpu_div.sv
rtl/fly_camera_pose_update.sv
rtl/fcpu_checker.sv
bench/fly_camera_pose_update_tb.sv
